>>> src/trie_pkg.sv
package trie_pkg;

  // Character range of valid letters starts here
  localparam logic [7:0] FIRST_LETTER = 8'h61;

  // Operation select
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADCH = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One character of a word
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       last;
  } in_t;

  // End-of-word answer
  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } out_t;

endpackage

>>> src/trie_ram.sv
module trie_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/trie_insert_search.sv
// Channel   Signals                     Direction  Handshake
// -------   -------------------------   ---------  ----------------------------------
// request   request.op/.ch/.last        in         taken when start && !busy
// result    result.found/.status        out        valid for the single cycle of done
//
// For each character the child-table read is issued in the accept cycle and
// the walk / allocate write happens in the next. A search word's last
// character on an intact path adds a word-mark read state before the result.
// The result strobe is registered from the last character's decision or mark read.
// After reset the block sweeps both memories to zero, one entry a cycle, over
// all NODE_COUNT*ALPHABET_SIZE child slots (26624 at the defaults) with busy held high.
// The receiver cannot stall; done is a one-cycle pulse.
module trie_insert_search #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  trie_pkg::in_t  request,
  output logic           busy,
  output logic           done,
  output trie_pkg::out_t result
);

  import trie_pkg::*;

  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = NODE_W + 1;
  localparam int LET_W      = $clog2(ALPHABET_SIZE);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_WALK  = 4'b0100,
    S_MARK  = 4'b1000
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   clr_cnt;
  logic [NODE_W-1:0]   cursor;
  logic                path_dead;
  logic [1:0]          word_status;
  logic [USED_W-1:0]   nodes_used;
  logic                op_r;
  logic                last_r;
  logic                bad_r;
  logic [SLOT_W-1:0]   slot_r;

  // Memory ports
  logic                child_we;
  logic [SLOT_W-1:0]   child_waddr;
  logic [NODE_W-1:0]   child_wdata;
  logic [NODE_W-1:0]   child_rd;
  logic                mark_we;
  logic [NODE_W-1:0]   mark_waddr;
  logic                mark_wdata;
  logic                mark_rd;

  // Accept-side decode
  logic [7:0]          diff;
  logic                bad_ch;
  logic [LET_W-1:0]    letter;
  logic [SLOT_W-1:0]   slot_addr;

  // Walk decision
  logic [1:0]          status_next;
  logic                dead_next;
  logic [NODE_W-1:0]   cursor_next;
  logic                alloc;
  logic                pool_full;
  logic                word_ok;
  logic                set_mark;
  logic                need_mark;

  assign busy = (state != S_IDLE);

  // Letter check and child slot of the current node
  always_comb begin
    diff      = request.ch - FIRST_LETTER;
    bad_ch    = (request.ch < FIRST_LETTER) || ({1'b0, diff} >= 9'(ALPHABET_SIZE));
    letter    = bad_ch ? '0 : diff[LET_W-1:0];
    slot_addr = SLOT_W'(cursor) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(letter);
  end

  // Follow, kill, allocate or flag an error on the child-table read data
  always_comb begin
    status_next = word_status;
    dead_next   = path_dead;
    cursor_next = cursor;
    alloc       = 1'b0;
    pool_full   = (nodes_used >= USED_W'(NODE_COUNT));
    if (word_status == ST_OK) begin
      if (bad_r) begin
        status_next = ST_BADCH;
      end else if (!path_dead) begin
        if (child_rd != '0) begin
          cursor_next = child_rd;
        end else if (op_r == OP_SEARCH) begin
          dead_next = 1'b1;
        end else if (pool_full) begin
          status_next = ST_FULL;
        end else begin
          alloc       = 1'b1;
          cursor_next = nodes_used[NODE_W-1:0];
        end
      end
    end
    word_ok   = (status_next == ST_OK) && !dead_next;
    set_mark  = last_r && word_ok && (op_r == OP_INSERT);
    need_mark = last_r && word_ok && (op_r == OP_SEARCH);
  end

  // Write ports: clearing sweep, new link, word mark.
  // Reads of an item always come in a later cycle than the previous item's writes,
  // so no forwarding is needed.
  always_comb begin
    child_we    = 1'b0;
    child_waddr = slot_r;
    child_wdata = nodes_used[NODE_W-1:0];
    mark_we     = 1'b0;
    mark_waddr  = cursor_next;
    mark_wdata  = 1'b0;
    if (state == S_CLEAR) begin
      child_we    = 1'b1;
      child_waddr = clr_cnt;
      child_wdata = '0;
      mark_we     = (clr_cnt < SLOT_W'(NODE_COUNT));
      mark_waddr  = clr_cnt[NODE_W-1:0];
    end else if (state == S_WALK) begin
      child_we = alloc;
      if (set_mark) begin
        mark_we    = 1'b1;
        mark_wdata = 1'b1;
      end else if (alloc) begin
        mark_we = 1'b1;
      end
    end
  end

  trie_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SLOT_COUNT)
  ) u_child (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (slot_addr),
    .rdata (child_rd)
  );

  trie_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (cursor_next),
    .rdata (mark_rd)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      cursor      <= '0;
      path_dead   <= 1'b0;
      word_status <= ST_OK;
      nodes_used  <= USED_W'(1);
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SLOT_W'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r   <= request.op;
            last_r <= request.last;
            bad_r  <= bad_ch;
            slot_r <= slot_addr;
            state  <= S_WALK;
          end
        end
        S_WALK: begin
          if (alloc) begin
            nodes_used <= nodes_used + 1'b1;
          end
          if (last_r) begin
            // end of word: walk state returns to the root
            cursor      <= '0;
            path_dead   <= 1'b0;
            word_status <= ST_OK;
            if (need_mark) begin
              state <= S_MARK;
            end else begin
              done          <= 1'b1;
              result.found  <= set_mark;
              result.status <= status_next;
              state         <= S_IDLE;
            end
          end else begin
            cursor      <= cursor_next;
            path_dead   <= dead_next;
            word_status <= status_next;
            state       <= S_IDLE;
          end
        end
        S_MARK: begin
          done          <= 1'b1;
          result.found  <= mark_rd;
          result.status <= ST_OK;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_WALK))
    else $error("accepted request did not enter the walk step");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_OK || !result.found))
    else $error("found set on an error result");

  assert property (@(posedge clk) disable iff (rst)
    (nodes_used != '0) && (nodes_used <= USED_W'(NODE_COUNT)))
    else $error("node pool count out of range");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |->
      ($past(state) == S_WALK && $past(last_r) && $past(op_r) == OP_SEARCH))
    else $error("mark lookup without a final search character");

endmodule

>>> test/tb_trie_insert_search.sv
module tb_trie_insert_search;
  timeunit 1ns;
  timeprecision 1ps;

  import trie_pkg::*;

  localparam int NODE_COUNT     = 1024;
  localparam int ALPHABET_SIZE  = 26;
  localparam int RANDOM_CHARS   = 577;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int MAX_WORD       = 8;

  // One directed row: a request and, where obvious, its answer typed in
  typedef struct packed {
    in_t  req;
    bit   given;
    out_t answer;
  } script_row_t;

  typedef struct packed {
    logic [8*MAX_WORD-1:0] chars;
    logic [3:0]            len;
  } word_t;

  localparam int SCRIPT_LEN = 23;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // search on an empty trie
    '{'{OP_SEARCH, "a", 1'b1}, 1'b1, '{1'b0, ST_OK}},
    // insert then search a two-letter word, then its unmarked prefix
    '{'{OP_INSERT, "a", 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_INSERT, "b", 1'b1}, 1'b1, '{1'b1, ST_OK}},
    '{'{OP_SEARCH, "a", 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_SEARCH, "b", 1'b1}, 1'b1, '{1'b1, ST_OK}},
    '{'{OP_SEARCH, "a", 1'b1}, 1'b0, '{1'b0, ST_OK}},
    // top letter of the alphabet
    '{'{OP_INSERT, "z", 1'b1}, 1'b1, '{1'b1, ST_OK}},
    '{'{OP_SEARCH, "z", 1'b1}, 1'b0, '{1'b0, ST_OK}},
    // bad characters on both sides of the letter range; first error wins
    '{'{OP_INSERT, 8'h60, 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_INSERT, "a", 1'b1}, 1'b1, '{1'b0, ST_BADCH}},
    '{'{OP_SEARCH, 8'hFF, 1'b1}, 1'b1, '{1'b0, ST_BADCH}},
    '{'{OP_INSERT, 8'h7B, 1'b1}, 1'b1, '{1'b0, ST_BADCH}},
    '{'{OP_SEARCH, 8'h00, 1'b1}, 1'b1, '{1'b0, ST_BADCH}},
    // missing link, then a bad character in the same word
    '{'{OP_SEARCH, "q", 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_SEARCH, 8'h80, 1'b1}, 1'b1, '{1'b0, ST_BADCH}},
    // dead search path followed by an insert character
    '{'{OP_SEARCH, "y", 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_INSERT, "y", 1'b1}, 1'b0, '{1'b0, ST_OK}},
    // insert character then search character in one word
    '{'{OP_INSERT, "c", 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_SEARCH, "c", 1'b1}, 1'b0, '{1'b0, ST_OK}},
    // node allocated before a bad character stays, but is not marked
    '{'{OP_INSERT, "d", 1'b0}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_INSERT, 8'h7B, 1'b1}, 1'b1, '{1'b0, ST_BADCH}},
    '{'{OP_SEARCH, "d", 1'b1}, 1'b0, '{1'b0, ST_OK}},
    '{'{OP_INSERT, "d", 1'b1}, 1'b1, '{1'b1, ST_OK}}
  };

  logic clk;
  logic rst;
  logic start;
  in_t  request;
  logic busy;
  logic done;
  out_t result;

  // Trie mirror: links, word marks, pool fill and the walk of the current word
  bit [9:0]   trie_links [NODE_COUNT][ALPHABET_SIZE];
  bit         word_marked [NODE_COUNT];
  int         pool_used = 1;
  bit [9:0]   walk_node;
  bit         walk_dead;
  logic [1:0] word_err = ST_OK;

  out_t  answer_q [$];
  word_t known_words [$];
  int    chars_sent;
  int    mismatches;
  int    quiet_cycles;
  out_t  want;

  trie_insert_search #(
    .NODE_COUNT    (NODE_COUNT),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one character request, wait for it to be taken, then advance the trie
  task automatic send_char(input in_t r, input bit given, input out_t given_ans);
    int   letter;
    bit   [9:0] nxt;
    out_t ans;
    // random gaps, except in one stretch of back-to-back requests
    while (!(chars_sent >= 250 && chars_sent < 400) && $urandom_range(99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    chars_sent++;

    letter = int'(r.ch) - int'(FIRST_LETTER);
    if (word_err == ST_OK) begin
      if (letter < 0 || letter >= ALPHABET_SIZE) begin
        word_err = ST_BADCH;
      end else if (!walk_dead) begin
        nxt = trie_links[walk_node][letter];
        if (nxt != 0) begin
          walk_node = nxt;
        end else if (r.op == OP_SEARCH) begin
          walk_dead = 1'b1;
        end else if (pool_used >= NODE_COUNT) begin
          word_err = ST_FULL;
        end else begin
          trie_links[walk_node][letter] = pool_used[9:0];
          word_marked[pool_used] = 1'b0;
          walk_node = pool_used[9:0];
          pool_used++;
        end
      end
    end

    // end of word: answer, then back to the root
    if (r.last) begin
      ans.status = word_err;
      ans.found  = 1'b0;
      if (word_err == ST_OK && !walk_dead) begin
        if (r.op == OP_INSERT) begin
          word_marked[walk_node] = 1'b1;
          ans.found = 1'b1;
        end else begin
          ans.found = word_marked[walk_node];
        end
      end
      answer_q.push_back(given ? given_ans : ans);
      walk_node = '0;
      walk_dead = 1'b0;
      word_err  = ST_OK;
    end
  endtask

  task automatic send_word(input word_t w, input logic [7:0] ops);
    in_t r;
    for (int i = 0; i < w.len; i++) begin
      r.op   = ops[i];
      r.ch   = w.chars[8*i +: 8];
      r.last = (i == w.len - 1);
      send_char(r, 1'b0, '0);
    end
  endtask

  // Mostly well-formed insert/search words over a narrow alphabet so that
  // searches hit; the rest are broken words, mixed ops and range edges
  task automatic random_word();
    word_t      w;
    logic [7:0] ops;
    int         kind;
    int         span;
    int         pos;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: span = 3;
      5, 6, 7:       span = 8;
      default:       span = ALPHABET_SIZE;
    endcase
    w.len = ($urandom_range(3) == 0) ? 4'($urandom_range(MAX_WORD, 1))
                                     : 4'($urandom_range(3, 1));
    for (int i = 0; i < MAX_WORD; i++) begin
      w.chars[8*i +: 8] = FIRST_LETTER + 8'($urandom_range(span - 1));
    end
    ops = (kind < 45) ? {8{OP_INSERT}} : {8{OP_SEARCH}};

    if (kind >= 45 && kind < 80) begin
      // search a known word, sometimes only its prefix
      if (known_words.size() != 0 && $urandom_range(9) < 7) begin
        w = known_words[$urandom_range(known_words.size() - 1)];
        if (w.len > 1 && $urandom_range(3) == 0) w.len = w.len - 4'd1;
      end
    end else if (kind >= 80 && kind < 88) begin
      // one raw byte somewhere in the word
      pos = $urandom_range(w.len - 1);
      w.chars[8*pos +: 8] = 8'($urandom_range(255));
      ops = $urandom_range(1) ? {8{OP_SEARCH}} : {8{OP_INSERT}};
    end else if (kind >= 88 && kind < 94) begin
      ops = 8'($urandom_range(255));
    end else if (kind >= 94) begin
      // letters at the range edges and their out-of-range neighbors
      for (int i = 0; i < MAX_WORD; i++) begin
        case ($urandom_range(3))
          0:       w.chars[8*i +: 8] = FIRST_LETTER - 8'd1;
          1:       w.chars[8*i +: 8] = FIRST_LETTER;
          2:       w.chars[8*i +: 8] = FIRST_LETTER + 8'(ALPHABET_SIZE - 1);
          default: w.chars[8*i +: 8] = FIRST_LETTER + 8'(ALPHABET_SIZE);
        endcase
      end
      ops = $urandom_range(1) ? {8{OP_SEARCH}} : {8{OP_INSERT}};
    end

    if (kind < 45) begin
      if (known_words.size() < 64) known_words.push_back(w);
      else known_words[$urandom_range(63)] = w;
    end
    send_word(w, ops);
  endtask

  // Result checker: every strobe must match the oldest expected answer
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d status=%0d", result.found, result.status);
      end else begin
        want = answer_q.pop_front();
        if (result.found !== want.found || result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: found exp %0d got %0d, status exp %0d got %0d",
                     $realtime, want.found, result.found, want.status, result.status);
        end
      end
    end
  end

  // Watchdog: cycles in which no request is taken and no result comes
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    chars_sent   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_char(SCRIPT[i].req, SCRIPT[i].given, SCRIPT[i].answer);
    end

    // random words
    while (chars_sent < SCRIPT_LEN + RANDOM_CHARS) random_word();

    start <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
